// ----- hdl/ufl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ufl_pkg
// Shared widths, the datapath vector type and the arctangent table for the
// unicycle feedback linearization inverse map.
// ----------------------------------------------------------------------------
package ufl_pkg;

	localparam int unsigned DATA_W    = 16;
	localparam int unsigned GUARD_W   = 8;
	localparam int unsigned XY_W      = 27;
	localparam int unsigned Z_W       = 32;
	localparam int unsigned ATAN_LEN  = 24;
	localparam int unsigned GAIN_W    = 31;
	localparam int unsigned RADIUS_FRAC = 12;

	localparam logic signed [GAIN_W-1:0] GAIN_COMP = 31'sd652032874;
	localparam logic [DATA_W-1:0] INV_RADIUS_RESET = 16'd4096;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} vec_t;

	function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] idx);
		logic signed [Z_W-1:0] a;
		case (idx)
			5'd0:  a = 32'sh20000000;
			5'd1:  a = 32'sh12E4051E;
			5'd2:  a = 32'sh09FB385B;
			5'd3:  a = 32'sh051111D4;
			5'd4:  a = 32'sh028B0D43;
			5'd5:  a = 32'sh0145D7E1;
			5'd6:  a = 32'sh00A2F61E;
			5'd7:  a = 32'sh00517C55;
			5'd8:  a = 32'sh0028BE53;
			5'd9:  a = 32'sh00145F2F;
			5'd10: a = 32'sh000A2F98;
			5'd11: a = 32'sh000517CC;
			5'd12: a = 32'sh00028BE6;
			5'd13: a = 32'sh000145F3;
			5'd14: a = 32'sh0000A2F9;
			5'd15: a = 32'sh0000517D;
			5'd16: a = 32'sh000028BE;
			5'd17: a = 32'sh0000145F;
			5'd18: a = 32'sh00000A30;
			5'd19: a = 32'sh00000518;
			5'd20: a = 32'sh0000028C;
			5'd21: a = 32'sh00000146;
			5'd22: a = 32'sh000000A3;
			5'd23: a = 32'sh00000051;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/unicycle_feedback_linearization.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// unicycle_feedback_linearization
// Inverse feedback linearization map: rotates (v_first, v_second) by minus the
// heading and scales the second component by inv_radius, Q8.8 saturated.
// ----------------------------------------------------------------------------
// The block takes one transaction in every clock cycle; busy is always low.
// Each result appears with done for one cycle, after passing through the
// quadrant register, the rotator pipeline of one stage per CORDIC step and
// the gain, rounding, radius-scaling and output saturation registers. The
// receiver cannot stall, so results are never held. Write inv_radius only
// while no transaction is in flight.
module unicycle_feedback_linearization #(
	parameter int unsigned ROTATION_STAGES = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [15:0]         heading,
	input  wire logic signed [15:0]  v_first,
	input  wire logic signed [15:0]  v_second,
	input  wire logic                cfg_we,
	input  wire logic [15:0]         cfg_wdata,
	output logic                     done,
	output logic signed [15:0]       u_linear,
	output logic signed [15:0]       u_angular,
	output logic                     saturated
);

	localparam int unsigned NUM_STAGES = (ROTATION_STAGES < ufl_pkg::ATAN_LEN) ?
		ROTATION_STAGES : ufl_pkg::ATAN_LEN;
	localparam int unsigned XY_W   = ufl_pkg::XY_W;
	localparam int unsigned PROD_W = XY_W + ufl_pkg::GAIN_W;
	localparam int unsigned XC_W   = PROD_W - 30;
	localparam int unsigned UL_W   = XC_W - ufl_pkg::GUARD_W;
	localparam int unsigned RP_W   = XC_W + ufl_pkg::DATA_W + 1;
	localparam int unsigned UA_SH  = ufl_pkg::GUARD_W + ufl_pkg::RADIUS_FRAC;
	localparam int unsigned UA_W   = RP_W - UA_SH;

	logic [15:0] inv_radius_q;

	// quadrant pre-rotation
	logic [15:0]               phi, shifted;
	logic [1:0]                quad;
	logic signed [14:0]        resid;
	logic signed [XY_W-1:0]    x_in, y_in;
	ufl_pkg::vec_t             vec_pre;
	logic                      valid_s1;
	ufl_pkg::vec_t             vec_s1;

	logic                      valid_c [0:NUM_STAGES];
	ufl_pkg::vec_t             vec_c   [0:NUM_STAGES];

	logic                      valid_s2;
	logic signed [PROD_W-1:0]  prod_x_s2, prod_y_s2;
	logic signed [PROD_W-1:0]  rnd_x, rnd_y;

	logic                      valid_s3;
	logic signed [XC_W-1:0]    xc_s3, yc_s3;
	logic signed [XC_W-1:0]    xc_rnd;
	logic signed [UL_W-1:0]    ul_full;

	logic                      valid_s4;
	logic signed [15:0]        ul_s4;
	logic                      clip_x_s4;
	logic signed [RP_W-1:0]    prod_r_s4;
	logic signed [RP_W-1:0]    rnd_r;
	logic signed [UA_W-1:0]    ua_full;

	logic                      done_q;
	logic signed [15:0]        u_linear_q, u_angular_q;
	logic                      saturated_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_radius_q <= ufl_pkg::INV_RADIUS_RESET;
		end else if (cfg_we) begin
			inv_radius_q <= cfg_wdata;
		end
	end

	always_comb begin
		phi     = 16'd0 - heading;
		shifted = phi + 16'h2000;
		quad    = shifted[15:14];
		resid   = $signed({1'b0, shifted[13:0]}) - 15'sd8192;
		x_in    = {{(XY_W-24){v_first[15]}}, v_first, 8'b0};
		y_in    = {{(XY_W-24){v_second[15]}}, v_second, 8'b0};
		vec_pre.z = {{(ufl_pkg::Z_W-31){resid[14]}}, resid, 16'b0};
		case (quad)
			2'd0: begin
				vec_pre.x = x_in;
				vec_pre.y = y_in;
			end
			2'd1: begin
				vec_pre.x = -y_in;
				vec_pre.y = x_in;
			end
			2'd2: begin
				vec_pre.x = -x_in;
				vec_pre.y = -y_in;
			end
			default: begin
				vec_pre.x = y_in;
				vec_pre.y = -x_in;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_c[NUM_STAGES];
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			done_q   <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		vec_s1 <= vec_pre;
	end

	assign valid_c[0] = valid_s1;
	assign vec_c[0]   = vec_s1;

	for (genvar g = 0; g < NUM_STAGES; g++) begin : g_rot
		ufl_cordic_stage #(
			.STAGE(g)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (valid_c[g]),
			.vec_in    (vec_c[g]),
			.valid_out (valid_c[g+1]),
			.vec_out   (vec_c[g+1])
		);
	end

	// gain compensation, rounding, radius scaling, saturation
	always_comb begin
		rnd_x   = prod_x_s2 + (PROD_W'(1) <<< 29);
		rnd_y   = prod_y_s2 + (PROD_W'(1) <<< 29);
		xc_rnd  = xc_s3 + XC_W'(128);
		ul_full = xc_rnd[XC_W-1:ufl_pkg::GUARD_W];
		rnd_r   = prod_r_s4 + (RP_W'(1) <<< (UA_SH - 1));
		ua_full = rnd_r[RP_W-1:UA_SH];
	end

	always_ff @(posedge clk) begin
		prod_x_s2 <= PROD_W'(vec_c[NUM_STAGES].x) * PROD_W'(ufl_pkg::GAIN_COMP);
		prod_y_s2 <= PROD_W'(vec_c[NUM_STAGES].y) * PROD_W'(ufl_pkg::GAIN_COMP);

		xc_s3 <= rnd_x[PROD_W-1:30];
		yc_s3 <= rnd_y[PROD_W-1:30];

		prod_r_s4 <= RP_W'(yc_s3) * $signed(RP_W'({1'b0, inv_radius_q}));
		if (ul_full > UL_W'(32767)) begin
			ul_s4     <= 16'sh7FFF;
			clip_x_s4 <= 1'b1;
		end else if (ul_full < -UL_W'(32768)) begin
			ul_s4     <= 16'sh8000;
			clip_x_s4 <= 1'b1;
		end else begin
			ul_s4     <= ul_full[15:0];
			clip_x_s4 <= 1'b0;
		end

		u_linear_q <= ul_s4;
		if (ua_full > UA_W'(32767)) begin
			u_angular_q <= 16'sh7FFF;
			saturated_q <= 1'b1;
		end else if (ua_full < -UA_W'(32768)) begin
			u_angular_q <= 16'sh8000;
			saturated_q <= 1'b1;
		end else begin
			u_angular_q <= ua_full[15:0];
			saturated_q <= clip_x_s4;
		end
	end

	assign done      = done_q;
	assign u_linear  = u_linear_q;
	assign u_angular = u_angular_q;
	assign saturated = saturated_q;

endmodule
`default_nettype wire

// ----- hdl/ufl_cordic_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ufl_cordic_stage
// One registered CORDIC rotation micro-step with a fixed shift of STAGE bits.
// ----------------------------------------------------------------------------
module ufl_cordic_stage #(
	parameter int unsigned STAGE = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          valid_in,
	input  wire ufl_pkg::vec_t vec_in,
	output logic               valid_out,
	output ufl_pkg::vec_t      vec_out
);

	localparam logic signed [ufl_pkg::Z_W-1:0] ATAN = ufl_pkg::atan_entry(5'(STAGE));

	logic signed [ufl_pkg::XY_W-1:0] x_in, y_in, dx, dy;
	logic signed [ufl_pkg::Z_W-1:0]  z_in;
	logic                            valid_s1;
	ufl_pkg::vec_t                   vec_s1;
	ufl_pkg::vec_t                   vec_nxt;

	always_comb begin
		x_in = vec_in.x;
		y_in = vec_in.y;
		z_in = vec_in.z;
		dx   = y_in >>> STAGE;
		dy   = x_in >>> STAGE;
		if (!z_in[ufl_pkg::Z_W-1]) begin
			vec_nxt.x = x_in - dx;
			vec_nxt.y = y_in + dy;
			vec_nxt.z = z_in - ATAN;
		end else begin
			vec_nxt.x = x_in + dx;
			vec_nxt.y = y_in - dy;
			vec_nxt.z = z_in + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		vec_s1 <= vec_nxt;
	end

	assign valid_out = valid_s1;
	assign vec_out   = vec_s1;

endmodule
`default_nettype wire

// ----- bench/unicycle_feedback_linearization_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unicycle_feedback_linearization_test
// Drives heading and virtual control samples into the inverse feedback
// linearization map and checks every result against a bit-exact CORDIC
// predictor kept in a scoreboard. Sweeps the inverse radius register through
// its extremes, with random idle gaps on the command side.
// ----------------------------------------------------------------------------

typedef struct {
	logic [15:0]        heading;
	logic signed [15:0] v_first;
	logic signed [15:0] v_second;
} control_sample_t;

typedef struct {
	logic signed [15:0] u_linear;
	logic signed [15:0] u_angular;
	logic               saturated;
} steering_t;

class inverse_map_board;
	int          stages;
	logic [15:0] inv_radius;
	longint      atan_turns[24];
	steering_t   pending_results[$];
	int unsigned errors;

	function new(int stages_in);
		stages = stages_in;
		inv_radius = 16'd4096;
		errors = 0;
		atan_turns = '{
			64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
			64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
			64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
			64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517D,
			64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
			64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
	endfunction

	function void set_radius(logic [15:0] value);
		inv_radius = value;
	endfunction

	function longint clip_q88(longint value, inout bit clipped);
		if (value > 32767) begin
			clipped = 1'b1;
			return 32767;
		end
		if (value < -32768) begin
			clipped = 1'b1;
			return -32768;
		end
		return value;
	endfunction

	function steering_t rotate_and_scale(control_sample_t s);
		logic [15:0] phi;
		logic [15:0] shifted;
		logic [1:0]  quarter;
		longint      x, y, z, t, dx, dy, xc, yc;
		bit          clipped;
		steering_t   r;
		clipped = 1'b0;
		phi = 16'd0 - s.heading;
		shifted = phi + 16'h2000;
		quarter = shifted[15:14];
		z = (longint'(shifted[13:0]) - 64'sd8192) * 64'sd65536;
		x = longint'(s.v_first) * 64'sd256;
		y = longint'(s.v_second) * 64'sd256;
		repeat (quarter) begin
			t = x;
			x = -y;
			y = t;
		end
		for (int i = 0; i < stages && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - atan_turns[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + atan_turns[i];
			end
		end
		xc = (x * 64'sd652032874 + (64'sd1 <<< 29)) >>> 30;
		yc = (y * 64'sd652032874 + (64'sd1 <<< 29)) >>> 30;
		r.u_linear = 16'(clip_q88((xc + 64'sd128) >>> 8, clipped));
		r.u_angular = 16'(clip_q88((yc * longint'(inv_radius) + (64'sd1 <<< 19)) >>> 20,
			clipped));
		r.saturated = clipped;
		return r;
	endfunction

	function void note_command(control_sample_t s);
		pending_results.push_back(rotate_and_scale(s));
	endfunction

	function void check_result(logic signed [15:0] u_linear, logic signed [15:0] u_angular,
			logic saturated);
		steering_t want;
		if (pending_results.size() == 0) begin
			$error("result with no transaction outstanding: u_linear %0d u_angular %0d",
				u_linear, u_angular);
			errors++;
			return;
		end
		want = pending_results.pop_front();
		if (u_linear !== want.u_linear) begin
			$error("u_linear: expected %0d, got %0d", want.u_linear, u_linear);
			errors++;
		end
		if (u_angular !== want.u_angular) begin
			$error("u_angular: expected %0d, got %0d", want.u_angular, u_angular);
			errors++;
		end
		if (saturated !== want.saturated) begin
			$error("saturated: expected %0d, got %0d", want.saturated, saturated);
			errors++;
		end
	endfunction
endclass

module unicycle_feedback_linearization_test;

	localparam int unsigned ROTATION_STAGES = 16;
	localparam int unsigned DRAIN_CYCLES = ROTATION_STAGES + 8;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [15:0]        heading = '0;
	logic signed [15:0] v_first = '0;
	logic signed [15:0] v_second = '0;
	logic               cfg_we = 1'b0;
	logic [15:0]        cfg_wdata = '0;
	logic               done;
	logic signed [15:0] u_linear;
	logic signed [15:0] u_angular;
	logic               saturated;

	inverse_map_board board = new(int'(ROTATION_STAGES));

	unicycle_feedback_linearization #(
		.ROTATION_STAGES(ROTATION_STAGES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.heading(heading),
		.v_first(v_first),
		.v_second(v_second),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.u_linear(u_linear),
		.u_angular(u_angular),
		.saturated(saturated)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				board.set_radius(cfg_wdata);
			if (start && !busy)
				board.note_command('{heading, v_first, v_second});
			if (done)
				board.check_result(u_linear, u_angular, saturated);
		end
	end

	task automatic send_command(input control_sample_t s);
		start <= 1'b1;
		heading <= s.heading;
		v_first <= s.v_first;
		v_second <= s.v_second;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic pause(input int unsigned cycles);
		if (cycles != 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_radius(input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= 16'($urandom);
		@(posedge clk);
	endtask

	function automatic int unsigned gap_length(input bit dense);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (dense || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic signed [15:0] pick_speed();
		int unsigned r;
		r = $urandom_range(0, 9);
		case (r)
			0, 1, 2, 3, 4: return 16'($urandom);
			5, 6: return 16'($urandom_range(0, 1023)) - 16'sd512;
			7: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			default: return 16'($urandom_range(0, 2)) - 16'sd1;
		endcase
	endfunction

	function automatic logic [15:0] pick_heading();
		if ($urandom_range(0, 9) < 7)
			return 16'($urandom);
		return {3'($urandom_range(0, 7)), 13'h0} + 16'($urandom_range(0, 2)) - 16'd1;
	endfunction

	task automatic random_commands(input int unsigned count);
		bit dense;
		dense = $urandom_range(0, 3) == 0;
		repeat (count) begin
			send_command('{pick_heading(), pick_speed(), pick_speed()});
			pause(gap_length(dense));
		end
	endtask

	control_sample_t directed[21] = '{
		'{16'h0000, 256, 0},         '{16'h0000, 0, 256},
		'{16'h4000, 256, 0},         '{16'h8000, 256, 0},
		'{16'hC000, 256, 0},         '{16'h2000, 32767, 32767},
		'{16'h2000, -32768, -32768}, '{16'hE000, 32767, -32768},
		'{16'hFFFF, 32767, 0},       '{16'h1FFF, -32768, 32767},
		'{16'h2001, 1, -1},          '{16'h6000, -1, -1},
		'{16'hA000, -32768, 0},      '{16'h1000, 12345, -4321},
		'{16'h7FFF, 0, 32767},       '{16'h8001, 0, -32768},
		'{16'hDFFF, 100, 200},       '{16'h4000, -32768, -32768},
		'{16'h0000, -32768, 32767},  '{16'h5555, 0, 0},
		'{16'hAAAA, 32767, 32767}};

	initial begin
		logic [15:0] radius_plan[7];
		radius_plan = '{16'd1, 16'd65535, 16'd0, 16'd4096,
			16'($urandom_range(1, 65535)), 16'($urandom_range(1, 8191)), 16'd2048};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_command(directed[i]);
			pause(gap_length(i < 10));
		end
		drain_results();

		foreach (radius_plan[p]) begin
			write_radius(radius_plan[p]);
			if (p == 2 || p == 1)
				foreach (directed[i])
					if (i % 4 == 1)
						send_command(directed[i]);
			random_commands(75);
			drain_results();
		end

		if (board.errors == 0 && board.pending_results.size() == 0)
			$display("unicycle_feedback_linearization_test: clean");
		else
			$display("unicycle_feedback_linearization_test: errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("unicycle_feedback_linearization_test: errors");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/ufl_pkg.sv
hdl/ufl_cordic_stage.sv
hdl/unicycle_feedback_linearization.sv
bench/unicycle_feedback_linearization_test.sv
